// File: rtl/rvaq_pkg.sv
// ----------------------------------------------------------------------------
// rvaq_pkg
// Shared types and constants of the regulator valve angle law pipeline.
// ----------------------------------------------------------------------------
package rvaq_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_SETPOINT  = 3'd0;
  localparam logic [2:0] REG_PROP_GAIN = 3'd1;
  localparam logic [2:0] REG_FF_GAIN   = 3'd2;
  localparam logic [2:0] REG_PROP_MAX  = 3'd3;
  localparam logic [2:0] REG_FF_MIN    = 3'd4;
  localparam logic [2:0] REG_FF_MAX    = 3'd5;
  localparam logic [2:0] REG_ANGLE_MIN = 3'd6;
  localparam logic [2:0] REG_ANGLE_MAX = 3'd7;

  localparam int DivSteps   = 17;  // quotient bits of the error division
  localparam int RootSteps  = 16;  // quotient bits of the gain over root search
  localparam logic signed [17:0] PROP_FLOOR = 18'sd0;
  localparam logic signed [17:0] FF_OFFSET  = 18'sd1253;
  localparam logic signed [18:0] ERR_LIM    = 19'sd131072;

  // Configuration seen by every stage.
  typedef struct packed {
    logic [14:0]        setpoint;
    logic [15:0]        prop_gain;
    logic [31:0]        ff_gain;
    logic [14:0]        prop_max;
    logic signed [15:0] ff_min;
    logic signed [15:0] ff_max;
    logic [11:0]        angle_min;
    logic [11:0]        angle_max;
  } cfg_t;

  // Payload carried through the iteration stages.
  typedef struct packed {
    logic        neg;    // error is negative
    logic        sat;    // error magnitude reaches the limit
    logic        pos;    // supply pressure above zero
    logic [16:0] rem;    // division remainder
    logic [16:0] quot;   // division quotient
    logic [14:0] s;      // supply pressure
    logic [63:0] t;      // squared feed-forward gain
    logic [63:0] p;      // q*q*s so far
    logic [31:0] qs;     // q*s so far
    logic [15:0] q;      // feed-forward quotient so far
  } pipe_t;

endpackage

// File: rtl/regulator_valve_angle_law.sv
// Stages: one front stage, 17 division stages (one quotient bit each, the root
// search in all but the last) and three output stages.
// Throughput: one sample pair per cycle; the whole pipeline holds while the
// output register is full and not taken.
// Reset: rst clears all valid bits and loads the configuration reset values.
// ----------------------------------------------------------------------------
// regulator_valve_angle_law
// Valve angle from feedback and supply pressure: proportional plus
// feed-forward term, clamped and scaled to tenths of a degree.
// ----------------------------------------------------------------------------
module regulator_valve_angle_law import rvaq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // feedback_pressure, supply_pressure
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // valve_angle, prop_term, ff_term, zero pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t               cfg;
  logic               adv;
  logic               f_valid;
  pipe_t              f_data;
  logic               i_valid;
  pipe_t              i_data;
  logic [11:0]        valve_angle;
  logic signed [15:0] prop_term;
  logic signed [15:0] ff_term;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint  <= 15'd3000;
      cfg.prop_gain <= '0;
      cfg.ff_gain   <= '0;
      cfg.prop_max  <= '0;
      cfg.ff_min    <= '0;
      cfg.ff_max    <= '0;
      cfg.angle_min <= '0;
      cfg.angle_max <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SETPOINT:  cfg.setpoint  <= cfg_data[14:0];
        REG_PROP_GAIN: cfg.prop_gain <= cfg_data[15:0];
        REG_FF_GAIN:   cfg.ff_gain   <= cfg_data;
        REG_PROP_MAX:  cfg.prop_max  <= cfg_data[14:0];
        REG_FF_MIN:    cfg.ff_min    <= cfg_data[15:0];
        REG_FF_MAX:    cfg.ff_max    <= cfg_data[15:0];
        REG_ANGLE_MIN: cfg.angle_min <= cfg_data[11:0];
        REG_ANGLE_MAX: cfg.angle_max <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is free or being taken.
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  rvaq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .fb        (s_tdata[15:0]),
    .sup       (s_tdata[31:16]),
    .out_valid (f_valid),
    .out       (f_data)
  );

  rvaq_iter u_iter (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .cfg       (cfg),
    .in_valid  (f_valid),
    .in        (f_data),
    .out_valid (i_valid),
    .out       (i_data)
  );

  rvaq_back u_back (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .cfg         (cfg),
    .in_valid    (i_valid),
    .in          (i_data),
    .out_valid   (m_tvalid),
    .valve_angle (valve_angle),
    .prop_term   (prop_term),
    .ff_term     (ff_term)
  );

  assign m_tdata = {4'b0000, ff_term, prop_term, valve_angle};

endmodule

// File: rtl/rvaq_front.sv
// ----------------------------------------------------------------------------
// rvaq_front
// First stage: error numerator, saturation test and squared gain.
// ----------------------------------------------------------------------------
module rvaq_front import rvaq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  cfg_t               cfg,
  input  logic               in_valid,
  input  logic signed [15:0] fb,
  input  logic signed [15:0] sup,
  output logic               out_valid,
  output pipe_t              out
);

  logic [14:0]        sp;
  logic signed [17:0] n;
  logic [16:0]        mag;
  pipe_t              nxt;

  // Setpoint of zero counts as one.
  assign sp  = (cfg.setpoint == 15'd0) ? 15'd1 : cfg.setpoint;
  assign n   = $signed({3'b000, sp}) - 18'(fb);
  assign mag = n[17] ? 17'(-n) : n[16:0];

  always_comb begin
    nxt      = '0;
    nxt.neg  = n[17];
    nxt.sat  = mag >= {1'b0, sp, 1'b0};
    nxt.pos  = !sup[15] && (sup != 16'sd0);
    nxt.rem  = mag;
    nxt.s    = sup[14:0];
    nxt.t    = {32'd0, cfg.ff_gain} * {32'd0, cfg.ff_gain};
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out <= nxt;
    end
  end

endmodule

// File: rtl/rvaq_iter.sv
// ----------------------------------------------------------------------------
// rvaq_iter
// One quotient bit per stage for the error division and for the
// feed-forward search, in the first RootSteps stages, of the largest q with q*q*s <= g*g.
// ----------------------------------------------------------------------------
module rvaq_iter import rvaq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  cfg_t  cfg,
  input  logic  in_valid,
  input  pipe_t in,
  output logic  out_valid,
  output pipe_t out
);

  logic [14:0] sp;
  pipe_t       st [0:DivSteps];
  pipe_t       nx [0:DivSteps-1];
  logic [DivSteps:0] vld;

  assign sp     = (cfg.setpoint == 15'd0) ? 15'd1 : cfg.setpoint;
  assign st[0]  = in;
  assign vld[0] = in_valid;

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[DivSteps:1] <= '0;
    end else if (adv) begin
      vld[DivSteps:1] <= vld[DivSteps-1:0];
    end
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_stage
    logic [16:0] tr;
    logic        dbit;

    // Restoring division step, quotient bit DivSteps-1-i.
    if (i == 0) begin : g_first
      assign tr = st[i].rem;
    end else begin : g_shift
      assign tr = {st[i].rem[15:0], 1'b0};
    end
    assign dbit = tr >= {2'b00, sp};

    if (i < RootSteps) begin : g_root
      localparam int K = RootSteps - 1 - i;
      logic [63:0] cand;

      // Candidate (q + 2^K)^2 * s built from running sums.
      assign cand = st[i].p + ({32'd0, st[i].qs} << (K + 1))
                    + ({49'd0, st[i].s} << (2 * K));

      always_comb begin
        nx[i]       = st[i];
        nx[i].rem   = dbit ? (tr - {2'b00, sp}) : tr;
        nx[i].quot[DivSteps-1-i] = dbit;
        if (cand <= st[i].t) begin
          nx[i].p    = cand;
          nx[i].qs   = st[i].qs + 32'({17'd0, st[i].s} << K);
          nx[i].q[K] = 1'b1;
        end
      end
    end else begin : g_div_only
      always_comb begin
        nx[i]      = st[i];
        nx[i].rem  = dbit ? (tr - {2'b00, sp}) : tr;
        nx[i].quot[DivSteps-1-i] = dbit;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[i+1] <= nx[i];
      end
    end
  end

  assign out       = st[DivSteps];
  assign out_valid = vld[DivSteps];

endmodule

// File: rtl/rvaq_back.sv
// ----------------------------------------------------------------------------
// rvaq_back
// Gain product, rounding, clamps and angle scaling over three stages.
// ----------------------------------------------------------------------------
module rvaq_back import rvaq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  cfg_t               cfg,
  input  logic               in_valid,
  input  pipe_t              in,
  output logic               out_valid,
  output logic [11:0]        valve_angle,
  output logic signed [15:0] prop_term,
  output logic signed [15:0] ff_term
);

  logic [2:0]         vld;
  logic signed [18:0] err;
  logic signed [17:0] qf;
  logic signed [17:0] ffc;
  logic signed [35:0] prod;
  logic signed [15:0] ff_a;
  logic signed [17:0] pr;
  logic signed [17:0] prc;
  logic signed [15:0] prop_b;
  logic signed [15:0] ff_b;
  logic signed [16:0] sum;
  logic signed [21:0] x;
  logic signed [21:0] lo;
  logic signed [21:0] hi;
  logic signed [21:0] xc;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  // Stage A: signed saturated error, gain product, feed-forward clamp (ff_max when supply is not positive).
  always_comb begin
    if (in.sat) begin
      err = in.neg ? -ERR_LIM : ERR_LIM;
    end else begin
      err = in.neg ? -$signed({2'b00, in.quot}) : $signed({2'b00, in.quot});
    end
    qf  = $signed({2'b00, in.q}) + FF_OFFSET;
    ffc = (qf < 18'(cfg.ff_min)) ? 18'(cfg.ff_min) : qf;
    ffc = (ffc > 18'(cfg.ff_max)) ? 18'(cfg.ff_max) : ffc;
    if (!in.pos) begin
      ffc = 18'(cfg.ff_max);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= 36'($signed({1'b0, cfg.prop_gain}) * err);
      ff_a <= ffc[15:0];
    end
  end

  // Stage B: round to nearest, halves up, then clamp.
  assign pr = 18'((prod + 36'sd131072) >>> 18);

  always_comb begin
    prc = (pr < PROP_FLOOR) ? PROP_FLOOR : pr;
    prc = (prc > $signed({3'b000, cfg.prop_max})) ? $signed({3'b000, cfg.prop_max}) : prc;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prop_b <= prc[15:0];
      ff_b   <= ff_a;
    end
  end

  // Stage C: ten times the sum, angle clamp, truncate to tenths.
  assign sum = 17'(prop_b) + 17'(ff_b);
  assign x   = (22'(sum) <<< 3) + (22'(sum) <<< 1);
  assign lo  = $signed({4'b0000, cfg.angle_min, 6'b000000});
  assign hi  = $signed({4'b0000, cfg.angle_max, 6'b000000});

  always_comb begin
    xc = (x < lo) ? lo : x;
    xc = (xc > hi) ? hi : xc;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      valve_angle <= xc[17:6];
      prop_term   <= prop_b;
      ff_term     <= ff_b;
    end
  end

  assign out_valid = vld[2];

endmodule
